// ----- src/skl_pkg.sv -----
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and codes for the sorted key list table: beat layouts,
// operation and status codes, and the per-cell control and flag bundles.
// ----------------------------------------------------------------------------
package skl_pkg;

    localparam int KEY_WIDTH    = 32;
    localparam int HANDLE_WIDTH = 16;
    localparam int COUNT_OUT_W  = 7;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    typedef struct packed {
        op_t                           operation;
        logic signed [KEY_WIDTH-1:0]   key;
        logic [HANDLE_WIDTH-1:0]       item_handle;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic [HANDLE_WIDTH-1:0]       found_handle;
        logic [COUNT_OUT_W-1:0]        entry_count;
    } out_beat_t;

    // one stored entry
    typedef struct packed {
        logic signed [KEY_WIDTH-1:0]   key;
        logic [HANDLE_WIDTH-1:0]       handle;
    } entry_t;

    // where a cell takes its next entry from
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_NEW   = 2'd3
    } sel_t;

    typedef struct packed {
        logic capture;  // latch compare flags against the incoming key
        sel_t sel;
    } cell_ctrl_t;

    typedef struct packed {
        logic ge;   // stored key >= probe key
        logic le;   // stored key <= probe key
        logic eq;   // stored key == probe key
    } cell_flags_t;

endpackage

// ----- src/sorted_key_list_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_list_table_core
// Bounded (key, handle) list built as a row of cells with insert, remove and
// search by key, optionally keeping entries sorted by key.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry one operation beat (insert, remove, search).
//   m_valid/m_ready/m_payload carry one result beat per operation: status,
//   handle of the removed or found entry, and the entry count afterwards.
//   cfg_wr_en/cfg_wr_data write the ordered-mode bit; write it only while idle.
// Timing:
//   on the accepting edge every cell latches its compare flags against the key;
//   in the update state a prefix over those flags picks the position, on insert
//   or remove the cells from it onward shift by one in the same cycle, and the
//   result lands in the output register. No beat is accepted during the update.
//   The next beat is accepted while a result still waits in the output
//   register; the update cycle stalls only if that register is still full.
// Reset:
//   aresetn empties the list and clears ordered mode; entry contents are not
//   cleared, since only the first entry_count cells are ever looked at.
// ----------------------------------------------------------------------------
module sorted_key_list_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  skl_pkg::in_beat_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output skl_pkg::out_beat_t  m_payload
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic                         ordered_reg;
    logic [CW-1:0]                count_reg, count_next;
    skl_pkg::op_t                 op_reg;
    skl_pkg::entry_t              new_reg;
    logic                         m_valid_reg, m_valid_next;
    skl_pkg::out_beat_t           m_beat_reg, m_beat_next;

    skl_pkg::entry_t              cell_q     [CAPACITY];
    skl_pkg::cell_flags_t         cell_flags [CAPACITY];
    skl_pkg::cell_ctrl_t          cell_ctrl  [CAPACITY];

    logic [CAPACITY-1:0]          occupied;
    logic [CAPACITY-1:0]          ins_req, ins_first, ins_after;
    logic [CAPACITY-1:0]          hit_req, hit_first, hit_after;
    logic                         le_last;
    logic                         list_full, list_empty, any_hit, append;
    logic                         accept, go;
    logic [skl_pkg::HANDLE_WIDTH-1:0] hit_handle;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign go      = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);

    // occupancy, candidate masks and flag of the last entry
    always_comb begin
        le_last = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            occupied[i] = CW'(i) < count_reg;
            ins_req[i]  = cell_flags[i].ge && occupied[i];
            hit_req[i]  = cell_flags[i].eq && occupied[i];
            if (count_reg == CW'(i + 1)) begin
                le_last = cell_flags[i].le;
            end
        end
    end

    skl_first #(.WIDTH(CAPACITY)) u_ins_first (
        .req   (ins_req),
        .first (ins_first),
        .after (ins_after)
    );

    skl_first #(.WIDTH(CAPACITY)) u_hit_first (
        .req   (hit_req),
        .first (hit_first),
        .after (hit_after)
    );

    assign list_full  = (count_reg == CW'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign any_hit    = |hit_req;
    assign append     = !ordered_reg || list_empty
                        || (!cell_flags[0].ge && le_last);

    // handle of the first matching entry
    always_comb begin
        hit_handle = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit_first[i]) begin
                hit_handle = hit_handle | cell_q[i].handle;
            end
        end
    end

    // per-cell load select
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctrl[i].capture = accept;
            cell_ctrl[i].sel     = skl_pkg::SEL_HOLD;
            if (go) begin
                unique case (op_reg)
                    skl_pkg::OP_INSERT: begin
                        if (!list_full) begin
                            if (append) begin
                                if (count_reg == CW'(i)) begin
                                    cell_ctrl[i].sel = skl_pkg::SEL_NEW;
                                end
                            end else if (ins_first[i]) begin
                                cell_ctrl[i].sel = skl_pkg::SEL_NEW;
                            end else if (ins_after[i]) begin
                                cell_ctrl[i].sel = skl_pkg::SEL_LEFT;
                            end
                        end
                    end
                    skl_pkg::OP_REMOVE: begin
                        if (hit_first[i] || hit_after[i]) begin
                            cell_ctrl[i].sel = skl_pkg::SEL_RIGHT;
                        end
                    end
                    skl_pkg::OP_SEARCH: ;
                    skl_pkg::OP_NONE:   ;
                    default:            ;
                endcase
            end
        end
    end

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        skl_pkg::entry_t left_e, right_e;
        if (g == 0) begin : g_head
            assign left_e = new_reg;
        end else begin : g_body
            assign left_e = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_e = cell_q[g];
        end else begin : g_mid
            assign right_e = cell_q[g+1];
        end

        skl_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[g]),
            .cmp_key     (s_payload.key),
            .new_entry   (new_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry_q     (cell_q[g]),
            .flags_q     (cell_flags[g])
        );
    end

    // result, count and sequencing
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_beat_next  = m_beat_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (go) begin
                    state_next               = ST_IDLE;
                    m_valid_next             = 1'b1;
                    m_beat_next.status       = skl_pkg::STATUS_OK;
                    m_beat_next.found_handle = '0;
                    unique case (op_reg)
                        skl_pkg::OP_INSERT: begin
                            if (list_full) begin
                                m_beat_next.status = skl_pkg::STATUS_FULL;
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        skl_pkg::OP_REMOVE: begin
                            if (any_hit) begin
                                m_beat_next.found_handle = hit_handle;
                                count_next = count_reg - CW'(1);
                            end else begin
                                m_beat_next.status = skl_pkg::STATUS_MISS;
                            end
                        end
                        skl_pkg::OP_SEARCH: begin
                            if (any_hit) begin
                                m_beat_next.found_handle = hit_handle;
                            end else begin
                                m_beat_next.status = skl_pkg::STATUS_MISS;
                            end
                        end
                        skl_pkg::OP_NONE: ;
                        default:          ;
                    endcase
                    m_beat_next.entry_count = skl_pkg::COUNT_OUT_W'(count_next);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ordered_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                ordered_reg <= cfg_wr_data;
            end
        end
    end

    // operation beat and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= s_payload.operation;
            new_reg.key    <= s_payload.key;
            new_reg.handle <= s_payload.item_handle;
        end
        m_beat_reg <= m_beat_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_beat_reg;

endmodule

// ----- src/skl_cell.sv -----
// ----------------------------------------------------------------------------
// skl_cell
// One slot of the list: holds an entry, compares it with the probe key, and
// loads from its left or right neighbor when the list opens or closes a gap.
// ----------------------------------------------------------------------------
module skl_cell (
    input  logic                aclk,
    input  skl_pkg::cell_ctrl_t ctrl,
    input  logic signed [skl_pkg::KEY_WIDTH-1:0] cmp_key,
    input  skl_pkg::entry_t     new_entry,
    input  skl_pkg::entry_t     left_entry,
    input  skl_pkg::entry_t     right_entry,
    output skl_pkg::entry_t     entry_q,
    output skl_pkg::cell_flags_t flags_q
);

    skl_pkg::entry_t      entry_reg;
    skl_pkg::entry_t      entry_next;
    skl_pkg::cell_flags_t flags_reg;
    skl_pkg::cell_flags_t flags_next;

    // entry load select
    always_comb begin
        unique case (ctrl.sel)
            skl_pkg::SEL_HOLD:  entry_next = entry_reg;
            skl_pkg::SEL_LEFT:  entry_next = left_entry;
            skl_pkg::SEL_RIGHT: entry_next = right_entry;
            skl_pkg::SEL_NEW:   entry_next = new_entry;
            default:            entry_next = entry_reg;
        endcase
    end

    // signed compare against the probe key
    always_comb begin
        flags_next.ge = $signed(entry_reg.key) >= $signed(cmp_key);
        flags_next.le = $signed(entry_reg.key) <= $signed(cmp_key);
        flags_next.eq = entry_reg.key == cmp_key;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctrl.capture) begin
            flags_reg <= flags_next;
        end
    end

    assign entry_q = entry_reg;
    assign flags_q = flags_reg;

endmodule

// ----- src/skl_first.sv -----
// ----------------------------------------------------------------------------
// skl_first
// Finds the lowest set bit of a vector and the mask of positions above it,
// using a log-depth prefix OR.
// ----------------------------------------------------------------------------
module skl_first #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] req,
    output logic [WIDTH-1:0] first,
    output logic [WIDTH-1:0] after
);

    localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] pre [LEVELS+1];

    // inclusive prefix OR, doubling span each level
    always_comb begin
        pre[0] = req;
        for (int l = 0; l < LEVELS; l++) begin
            pre[l+1] = pre[l] | (pre[l] << (1 << l));
        end
    end

    // positions strictly above the first set bit
    assign after = {pre[LEVELS][WIDTH-2:0], 1'b0};
    assign first = req & ~after;

endmodule

// ----- tb/list_table_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// list_table_tb_pkg
// Scoreboard for the sorted key list table: keeps its own copy of the list
// and the mode bit, computes the expected result beat of each accepted
// operation and checks the result beats against them in order.
// ----------------------------------------------------------------------------
package list_table_tb_pkg;

    import skl_pkg::*;

    localparam int TABLE_DEPTH = 64;

    class key_list_tracker;

        // shadow copy of the table
        logic signed [KEY_WIDTH-1:0] keys [TABLE_DEPTH];
        logic [HANDLE_WIDTH-1:0]     handles [TABLE_DEPTH];
        int                          held;
        bit                          ordered;

        out_beat_t                   pending_results [$];

        // run statistics
        int mismatches;
        int n_results;
        int n_insert;
        int n_remove;
        int n_search;
        int n_none;
        int n_full;
        int n_miss;
        int peak;

        function new();
            held       = 0;
            ordered    = 1'b0;
            mismatches = 0;
            n_results  = 0;
            n_insert   = 0;
            n_remove   = 0;
            n_search   = 0;
            n_none     = 0;
            n_full     = 0;
            n_miss     = 0;
            peak       = 0;
        endfunction

        function void set_mode(bit mode);
            ordered = mode;
        endfunction

        function int size();
            return held;
        endfunction

        function logic signed [KEY_WIDTH-1:0] held_key(int idx);
            return keys[idx];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // apply one accepted operation beat and queue its result
        function void note_op(in_beat_t beat);
            out_beat_t res;
            int        pos;
            res = '0;
            case (beat.operation)
                OP_INSERT: begin
                    n_insert++;
                    if (held >= TABLE_DEPTH) begin
                        res.status = STATUS_FULL;
                        n_full++;
                    end else begin
                        pos = held;
                        // ordered placement: first, last, else before first >= key
                        if (ordered && held > 0) begin
                            if (beat.key <= keys[0]) begin
                                pos = 0;
                            end else if (!(keys[held-1] <= beat.key)) begin
                                for (int i = 1; i < held; i++) begin
                                    if (keys[i] >= beat.key) begin
                                        pos = i;
                                        break;
                                    end
                                end
                            end
                        end
                        for (int i = held; i > pos; i--) begin
                            keys[i]    = keys[i-1];
                            handles[i] = handles[i-1];
                        end
                        keys[pos]    = beat.key;
                        handles[pos] = beat.item_handle;
                        held++;
                    end
                end
                OP_REMOVE, OP_SEARCH: begin
                    if (beat.operation == OP_REMOVE) begin
                        n_remove++;
                    end else begin
                        n_search++;
                    end
                    // first match in list order
                    pos = held;
                    for (int i = 0; i < held; i++) begin
                        if (keys[i] == beat.key) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= held) begin
                        res.status = STATUS_MISS;
                        n_miss++;
                    end else begin
                        res.found_handle = handles[pos];
                        if (beat.operation == OP_REMOVE) begin
                            for (int i = pos; i + 1 < held; i++) begin
                                keys[i]    = keys[i+1];
                                handles[i] = handles[i+1];
                            end
                            held--;
                        end
                    end
                end
                default: begin
                    n_none++;
                end
            endcase
            if (held > peak) begin
                peak = held;
            end
            res.entry_count = COUNT_OUT_W'(held);
            pending_results.push_back(res);
        endfunction

        function void flag(string what, out_beat_t want, out_beat_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected status %0d handle %h count %0d, got status %0d handle %h count %0d",
                         $time, what, want.status, want.found_handle, want.entry_count,
                         got.status, got.found_handle, got.entry_count);
            end
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(out_beat_t got);
            out_beat_t want;
            n_results++;
            if (pending_results.size() == 0) begin
                flag("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found_handle !== want.found_handle ||
                    got.entry_count !== want.entry_count) begin
                    flag("result mismatch", want, got);
                end
            end
        endfunction

    endclass

endpackage

// ----- tb/tb_sorted_key_list_table_core.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_key_list_table_core
// Self-checking bench for the sorted key list table: directed edge cases,
// then random operation mixes in both list modes with random idling on
// both channels, checked beat by beat against a scoreboard.
// ----------------------------------------------------------------------------
module tb_sorted_key_list_table_core;

    timeunit 1ns;
    timeprecision 1ps;

    import skl_pkg::*;
    import list_table_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh80000000;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_beat_t  s_payload   = '0;
    logic      m_valid;
    logic      m_ready     = 1'b1;
    out_beat_t m_payload;

    bit idling_on   = 1'b1;
    int quiet_cycles = 0;

    key_list_tracker tracker = new();

    sorted_key_list_table_core #(
        .CAPACITY (TABLE_DEPTH)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // beat monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.check_result(m_payload);
            end
            if (s_valid && s_ready) begin
                tracker.note_op(s_payload);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // present one operation beat, optionally after a gap, and wait for accept
    task automatic send_op(input op_t op, input logic signed [KEY_WIDTH-1:0] key,
                           input logic [HANDLE_WIDTH-1:0] handle);
        in_beat_t beat;
        int       gap;
        beat.operation   = op;
        beat.key         = key;
        beat.item_handle = handle;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (tracker.pending() != 0) @(negedge aclk);
    endtask

    // mode write only with the table idle
    task automatic set_ordered(input bit mode);
        drain_results();
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_mode(mode);
    endtask

    // random operation mix; lookups mostly aim at keys currently held
    task automatic run_random(input int n_ops, input int insert_pct);
        op_t                         op;
        logic signed [KEY_WIDTH-1:0] key;
        int                          roll;
        for (int i = 0; i < n_ops; i++) begin
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
                key = int'($urandom_range(0, 16)) - 8;
            end else if (roll < 6) begin
                case ($urandom_range(0, 5))
                    0: key = KEY_MAX;
                    1: key = KEY_MIN;
                    2: key = KEY_MAX - 1;
                    3: key = KEY_MIN + 1;
                    4: key = 0;
                    default: key = -1;
                endcase
            end else begin
                key = 32'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = OP_NONE;
            end else if (roll < insert_pct) begin
                op = OP_INSERT;
            end else begin
                op = ($urandom_range(0, 1) == 1) ? OP_REMOVE : OP_SEARCH;
                if (tracker.size() > 0 && $urandom_range(0, 9) < 6) begin
                    key = tracker.held_key($urandom_range(0, tracker.size() - 1));
                end
            end
            send_op(op, key, 16'($urandom));
        end
        end_burst();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // unordered mode out of reset: empty lookups, extremes, duplicates
        send_op(OP_REMOVE, 0, 16'h1234);
        send_op(OP_SEARCH, -1, 16'h0000);
        send_op(OP_NONE, 32'($urandom), 16'($urandom));
        send_op(OP_INSERT, KEY_MAX, 16'hffff);
        send_op(OP_INSERT, KEY_MIN, 16'h0000);
        send_op(OP_INSERT, 5, 16'h0001);
        send_op(OP_INSERT, 5, 16'h0002);
        send_op(OP_SEARCH, 5, 16'h0000);
        send_op(OP_REMOVE, 5, 16'h0000);
        send_op(OP_SEARCH, 5, 16'h0000);
        send_op(OP_SEARCH, KEY_MIN, 16'h0000);
        send_op(OP_REMOVE, KEY_MAX, 16'h0000);
        send_op(OP_REMOVE, 12345, 16'h0000);
        send_op(OP_NONE, 32'($urandom), 16'($urandom));
        end_burst();

        // ordered mode with entries held: first, last, middle and equal keys
        set_ordered(1'b1);
        send_op(OP_INSERT, KEY_MAX, 16'ha5a5);
        send_op(OP_INSERT, KEY_MIN, 16'h5a5a);
        send_op(OP_INSERT, 7, 16'h0007);
        send_op(OP_INSERT, 6, 16'h0006);
        send_op(OP_INSERT, -100, 16'hff9c);
        send_op(OP_INSERT, 5, 16'h0555);
        send_op(OP_SEARCH, 5, 16'h0000);
        send_op(OP_REMOVE, KEY_MIN, 16'h0000);
        send_op(OP_SEARCH, KEY_MIN, 16'h0000);
        send_op(OP_NONE, 32'($urandom), 16'($urandom));
        end_burst();

        // random phases: fill to full, drain, switch modes with entries held
        set_ordered(1'b1);
        run_random(90, 90);
        run_random(60, 20);
        set_ordered(1'b0);
        run_random(70, 60);
        set_ordered(1'b1);
        run_random(70, 55);
        set_ordered(1'b0);
        run_random(70, 88);
        set_ordered(1'b1);
        idling_on = 1'b0;
        run_random(80, 35);

        drain_results();
        repeat (10) @(negedge aclk);

        $display("covered %0d inserts (%0d rejected as full), %0d removes, %0d searches, %0d unused-op beats",
                 tracker.n_insert, tracker.n_full, tracker.n_remove, tracker.n_search,
                 tracker.n_none);
        $display("%0d results checked, %0d lookup misses, peak fill %0d of %0d, both list modes",
                 tracker.n_results, tracker.n_miss, tracker.peak, TABLE_DEPTH);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", tracker.mismatches,
                     tracker.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/skl_pkg.sv
src/skl_cell.sv
src/skl_first.sv
src/sorted_key_list_table_core.sv
tb/list_table_tb_pkg.sv
tb/tb_sorted_key_list_table_core.sv
